// ===== hw/rtl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that cons holds in the same cycle as ante, outside of reset.
`define ASSERT_SAME_CYCLE(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Checks that cons holds in the cycle after ante, outside of reset.
`define ASSERT_NEXT_CYCLE(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/hhi_pkg.sv =====
`timescale 1ns / 1ps

package hhi_pkg;

  localparam int unsigned TimeW      = 63;
  localparam int unsigned HeightW    = 32;
  localparam int unsigned EntryW     = TimeW + HeightW;
  localparam int unsigned DivSteps   = HeightW;
  localparam int unsigned DivCntW    = $clog2(DivSteps);
  localparam int unsigned MinSamples = 2;

  typedef logic [TimeW-1:0]          stamp_t;
  typedef logic signed [HeightW-1:0] height_t;

  typedef enum logic [1:0] {
    RES_NONE,
    RES_EXACT,
    RES_INTERP
  } res_sel_t;

  typedef struct packed {
    logic     push;
    logic     load_query;
    logic     scan_en;
    logic     prep;
    logic     mul_lo;
    logic     mul_hi;
    logic     div_step;
    logic     load_out;
    res_sel_t res_sel;
  } hhi_cmd_t;

  typedef struct packed {
    logic few;
    logic scan_done;
    logic exact;
    logic lo_below;
    logic has_hi;
  } hhi_sts_t;

endpackage

// ===== hw/rtl/hhi_if.sv =====
`timescale 1ns / 1ps

interface hhi_in_if;
  logic             valid;
  logic             ready;
  logic             action;
  hhi_pkg::stamp_t  time_value;
  hhi_pkg::height_t height_in;

  modport source (output valid, action, time_value, height_in, input ready);
  modport sink   (input valid, action, time_value, height_in, output ready);
endinterface

interface hhi_out_if;
  logic             valid;
  logic             ready;
  logic             found;
  hhi_pkg::height_t height_out;

  modport source (output valid, found, height_out, input ready);
  modport sink   (input valid, found, height_out, output ready);
endinterface

// ===== hw/rtl/hhi_ram.sv =====
`timescale 1ns / 1ps

module hhi_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem_r[rd_addr];
    end
  end

endmodule

// ===== hw/rtl/hhi_dp.sv =====
`timescale 1ns / 1ps

module hhi_dp #(
  parameter int unsigned HISTORY_DEPTH = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  hhi_pkg::hhi_cmd_t cmd,
  output hhi_pkg::hhi_sts_t sts,
  input  hhi_pkg::stamp_t   in_time,
  input  hhi_pkg::height_t  in_height,
  output logic              out_found,
  output hhi_pkg::height_t  out_height
);

  import hhi_pkg::*;

  localparam int unsigned AW = $clog2(HISTORY_DEPTH);
  localparam int unsigned FW = $clog2(HISTORY_DEPTH + 1);
  localparam int unsigned KW = $clog2(HISTORY_DEPTH + 2);

  // History pointers.
  logic [FW-1:0] fill_r;
  logic [AW-1:0] oldest_r;
  logic          full;
  logic [KW:0]   wr_sum, rd_sum;
  logic [KW:0]   wr_wrap, rd_wrap;
  logic [AW-1:0] wr_slot, rd_slot;

  // Scan pipeline.
  logic [KW-1:0]     iss_k_r, ret_k_r, last_k;
  logic              rd_vld_r, has_hi_r;
  logic [EntryW-1:0] rd_data;
  stamp_t            rd_t;
  height_t           rd_h;
  logic              proc, is_first, above, at_end;

  // Query operands.
  stamp_t  t_r, lo_t_r, hi_t_r;
  height_t lo_h_r, hi_h_r;

  // Interpolation.
  stamp_t               num_r;
  logic [TimeW-1:0]     den_r;
  logic [HeightW-1:0]   mag_r;
  logic                 neg_r;
  logic [HeightW:0]     diff, diff_abs;
  logic [HeightW-1:0]   mul_b;
  logic [2*HeightW-1:0] mul_p, acc_r;
  logic [TimeW-1:0]     rem_r;
  logic [HeightW-1:0]   dq_r, q_clamped, res;
  logic [TimeW:0]       trial, trial_sub;
  logic                 ge;

  assign full   = (fill_r == FW'(HISTORY_DEPTH));
  assign last_k = KW'(fill_r) - KW'(1);

  // Slot of a position counted from the oldest sample, wrapped once.
  always_comb begin
    wr_sum  = (KW+1)'(oldest_r) + (KW+1)'(fill_r);
    rd_sum  = (KW+1)'(oldest_r) + (KW+1)'(iss_k_r);
    wr_wrap = (wr_sum >= (KW+1)'(HISTORY_DEPTH)) ? wr_sum - (KW+1)'(HISTORY_DEPTH) : wr_sum;
    rd_wrap = (rd_sum >= (KW+1)'(HISTORY_DEPTH)) ? rd_sum - (KW+1)'(HISTORY_DEPTH) : rd_sum;
    wr_slot = wr_wrap[AW-1:0];
    rd_slot = rd_wrap[AW-1:0];
  end

  hhi_ram #(
    .WIDTH (EntryW),
    .DEPTH (HISTORY_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (cmd.push),
    .wr_addr (wr_slot),
    .wr_data ({in_time, in_height}),
    .rd_en   (cmd.scan_en),
    .rd_addr (rd_slot),
    .rd_data (rd_data)
  );

  assign rd_t     = rd_data[EntryW-1:HeightW];
  assign rd_h     = rd_data[HeightW-1:0];
  assign proc     = cmd.scan_en && rd_vld_r;
  assign is_first = (ret_k_r == '0);
  assign above    = (rd_t > t_r);
  assign at_end   = (ret_k_r == last_k);

  always_comb begin
    sts.few       = (fill_r < FW'(MinSamples));
    sts.scan_done = proc && !is_first && (above || at_end);
    sts.exact     = (lo_t_r == t_r);
    sts.lo_below  = (lo_t_r < t_r);
    sts.has_hi    = has_hi_r;
  end

  // Control state of the history and the scan.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r   <= '0;
      oldest_r <= '0;
      rd_vld_r <= 1'b0;
      has_hi_r <= 1'b0;
      iss_k_r  <= '0;
      ret_k_r  <= '0;
    end else begin
      if (cmd.push) begin
        if (!full) begin
          fill_r <= fill_r + FW'(1);
        end else if (oldest_r == AW'(HISTORY_DEPTH - 1)) begin
          oldest_r <= '0;
        end else begin
          oldest_r <= oldest_r + AW'(1);
        end
      end
      if (cmd.load_query) begin
        iss_k_r  <= '0;
        ret_k_r  <= '0;
        rd_vld_r <= 1'b0;
        has_hi_r <= 1'b0;
      end else if (cmd.scan_en) begin
        iss_k_r  <= iss_k_r + KW'(1);
        // The entry read this cycle returns on the next one.
        ret_k_r  <= iss_k_r;
        rd_vld_r <= 1'b1;
        if (proc && !is_first && above) begin
          has_hi_r <= 1'b1;
        end
      end
    end
  end

  // Operand preparation and the shared 32 x 32 multiplier.
  always_comb begin
    diff     = {hi_h_r[HeightW-1], hi_h_r} - {lo_h_r[HeightW-1], lo_h_r};
    diff_abs = diff[HeightW] ? (~diff + (HeightW+1)'(1)) : diff;
    mul_b    = cmd.mul_hi ? {1'b0, num_r[TimeW-1:HeightW]} : num_r[HeightW-1:0];
    mul_p    = {{HeightW{1'b0}}, mag_r} * {{HeightW{1'b0}}, mul_b};
  end

  // One restoring division step per cycle.
  always_comb begin
    trial     = {rem_r, dq_r[HeightW-1]};
    trial_sub = trial - {1'b0, den_r};
    ge        = (trial >= {1'b0, den_r});
  end

  // The quotient never exceeds the height step, the clamp only guards it.
  always_comb begin
    q_clamped = (dq_r > mag_r) ? mag_r : dq_r;
    res       = neg_r ? (lo_h_r - q_clamped) : (lo_h_r + q_clamped);
  end

  always_ff @(posedge clk) begin
    if (cmd.load_query) begin
      t_r <= in_time;
    end
    if (proc) begin
      if (is_first || !above) begin
        lo_t_r <= rd_t;
        lo_h_r <= rd_h;
      end else begin
        hi_t_r <= rd_t;
        hi_h_r <= rd_h;
      end
    end
    if (cmd.prep) begin
      num_r <= t_r - lo_t_r;
      den_r <= hi_t_r - lo_t_r;
      neg_r <= diff[HeightW];
      mag_r <= diff_abs[HeightW-1:0];
    end
    if (cmd.mul_lo) begin
      acc_r <= mul_p;
    end
    if (cmd.mul_hi) begin
      rem_r <= mul_p[TimeW-1:0] + {{(TimeW-HeightW){1'b0}}, acc_r[2*HeightW-1:HeightW]};
      dq_r  <= acc_r[HeightW-1:0];
    end
    if (cmd.div_step) begin
      rem_r <= ge ? trial_sub[TimeW-1:0] : trial[TimeW-1:0];
      dq_r  <= {dq_r[HeightW-2:0], ge};
    end
    if (cmd.load_out) begin
      case (cmd.res_sel)
        RES_EXACT: begin
          out_found  <= 1'b1;
          out_height <= lo_h_r;
        end
        RES_INTERP: begin
          out_found  <= 1'b1;
          out_height <= res;
        end
        default: begin
          out_found  <= 1'b0;
          out_height <= '0;
        end
      endcase
    end
  end

endmodule

// ===== hw/rtl/hhi_ctrl.sv =====
`timescale 1ns / 1ps

module hhi_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_action,
  output logic              in_ready,
  input  logic              out_ready,
  output logic              out_valid,
  output hhi_pkg::hhi_cmd_t cmd,
  input  hhi_pkg::hhi_sts_t sts
);

  import hhi_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EVAL,
    ST_PREP,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_DIV,
    ST_FIN
  } state_t;

  localparam logic ActPush = 1'b0;

  state_t              state_r, state_nxt;
  logic                out_valid_r, out_valid_nxt;
  res_sel_t            sel_r, sel_nxt;
  logic [DivCntW-1:0]  div_cnt_r, div_cnt_nxt;

  // No request is taken while reset is held.
  assign in_ready  = rst_n && (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    sel_nxt       = sel_r;
    div_cnt_nxt   = div_cnt_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    cmd.res_sel   = sel_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_action == ActPush) begin
            cmd.push = 1'b1;
          end else begin
            cmd.load_query = 1'b1;
            if (sts.few) begin
              sel_nxt   = RES_NONE;
              state_nxt = ST_FIN;
            end else begin
              state_nxt = ST_SCAN;
            end
          end
        end
      end
      ST_SCAN: begin
        cmd.scan_en = 1'b1;
        if (sts.scan_done) begin
          state_nxt = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (sts.exact) begin
          sel_nxt   = RES_EXACT;
          state_nxt = ST_FIN;
        end else if (sts.has_hi && sts.lo_below) begin
          state_nxt = ST_PREP;
        end else begin
          sel_nxt   = RES_NONE;
          state_nxt = ST_FIN;
        end
      end
      ST_PREP: begin
        cmd.prep  = 1'b1;
        state_nxt = ST_MUL_LO;
      end
      ST_MUL_LO: begin
        cmd.mul_lo = 1'b1;
        state_nxt  = ST_MUL_HI;
      end
      ST_MUL_HI: begin
        cmd.mul_hi  = 1'b1;
        div_cnt_nxt = '0;
        state_nxt   = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        div_cnt_nxt  = div_cnt_r + DivCntW'(1);
        if (div_cnt_r == DivCntW'(DivSteps - 1)) begin
          sel_nxt   = RES_INTERP;
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!out_valid_r || out_ready) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      sel_r       <= RES_NONE;
      div_cnt_r   <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      sel_r       <= sel_nxt;
      div_cnt_r   <= div_cnt_nxt;
    end
  end

endmodule

// ===== hw/rtl/height_history_interpolator.sv =====
// Channel   Dir  Request contents
// in_ch     in   action (0 push, 1 query), time_value, height_in
// out_ch    out  found, height_out (one per query, none per push)
//
// A push writes its sample into the history memory at the accept edge.
// A query scans the history from its oldest entry, one entry per cycle, up to the first entry
// past the query time or the newest one; it then selects the result, prepares the operands to
// interpolate, multiplies in low and high halves, divides and loads the result register.
// Reset clears the fill count, oldest pointer, scan and control state; the memory needs no clearing pass.
// A waiting result does not block requests; a later query holds in its last cycle until taken.
`timescale 1ns / 1ps

`include "assert_macros.svh"

module height_history_interpolator #(
  parameter int unsigned HISTORY_DEPTH = 64
) (
  input logic       clk,
  input logic       rst_n,
  hhi_in_if.sink    in_ch,
  hhi_out_if.source out_ch
);

  import hhi_pkg::*;

  // Commands from the sequencer and status back from the datapath.
  hhi_cmd_t cmd;
  hhi_sts_t sts;

  // The sequencer owns both handshakes: it accepts a request only when idle and
  // raises the output valid when a result has been loaded into the datapath's
  // output register.
  hhi_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_action (in_ch.action),
    .in_ready  (in_ch.ready),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .cmd       (cmd),
    .sts       (sts)
  );

  // The datapath holds the circular history, the scan registers, the multiplier,
  // the divider and the result register.
  hhi_dp #(
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_time    (in_ch.time_value),
    .in_height  (in_ch.height_in),
    .out_found  (out_ch.found),
    .out_height (out_ch.height_out)
  );

  // A result must never overwrite one that has not been taken yet.
  `ASSERT_SAME_CYCLE(a_out_free, cmd.load_out, !out_ch.valid || out_ch.ready, "result lost")
  // No request may be accepted while a query is scanning or dividing.
  `ASSERT_SAME_CYCLE(a_busy_no_accept, cmd.scan_en || cmd.div_step, !in_ch.ready, "busy accept")
  // A query with at least two samples held starts its scan on the next cycle.
  `ASSERT_NEXT_CYCLE(a_query_scans, cmd.load_query && !sts.few, cmd.scan_en, "scan not started")

endmodule
